// ===== hw/rtl/art_pkg.sv =====
// ----------------------------------------------------------------------------
// art_pkg
// Shared types and constants of the pending-acknowledgement tracker: field
// widths, operation and event codes, register indexes and reset values.
// ----------------------------------------------------------------------------
package art_pkg;

	// Field widths
	localparam int FUNC_W    = 2;
	localparam int MSG_ID_W  = 16;
	localparam int PEER_W    = 56;
	localparam int TIME_W    = 32;
	localparam int EVENT_W   = 3;
	localparam int SLOT_W    = 3;
	localparam int RETRY_W   = 4;
	localparam int TIMEOUT_W = 20;

	// Configuration port
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 20;

	localparam logic [CFG_IDX_W-1:0] CFG_ACK_TIMEOUT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_RETRY_LIMIT = 2'd1;

	localparam logic [TIMEOUT_W-1:0] ACK_TIMEOUT_RST = 20'd1200;
	localparam logic [RETRY_W-1:0]   RETRY_LIMIT_RST = 4'd3;

	// Operation codes of an input item
	localparam logic [FUNC_W-1:0] FN_ADD  = 2'd0;
	localparam logic [FUNC_W-1:0] FN_ACK  = 2'd1;
	localparam logic [FUNC_W-1:0] FN_SCAN = 2'd2;

	// Result event codes
	typedef enum logic [EVENT_W-1:0] {
		EV_ADDED    = 3'd0,
		EV_FULL     = 3'd1,
		EV_ACK_OK   = 3'd2,
		EV_ACK_NONE = 3'd3,
		EV_RETRY    = 3'd4,
		EV_FAIL     = 3'd5,
		EV_DONE     = 3'd6
	} event_t;

	// Controller to datapath commands
	typedef struct packed {
		logic   req_ld;     // latch the accepted request
		logic   idx_clr;    // rewind the slot walk
		logic   idx_inc;    // advance the slot walk
		logic   emit;       // load the result register
		logic   last;       // final result of this item
		event_t ev;         // event reported
		logic   add_wr;     // store request into first free slot
		logic   slot_free;  // free the walked slot
		logic   slot_retry; // bump retries and restamp walked slot
	} art_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic any_free;  // at least one free slot
		logic hit;       // walked slot matches the ack request
		logic expired;   // walked slot is valid and timed out
		logic at_limit;  // walked slot has used all retries
		logic idx_last;  // walk is at the final slot
		logic out_free;  // result register can take a new result
	} art_sts_t;

endpackage

// ===== hw/rtl/art_if.sv =====
// ----------------------------------------------------------------------------
// art_if
// Channel interfaces of the tracker: request, result and configuration
// write, each with valid/ready handshake.
// ----------------------------------------------------------------------------
interface art_req_if import art_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [FUNC_W-1:0]   func;
	logic [MSG_ID_W-1:0] msg_id;
	logic [PEER_W-1:0]   peer_call;
	logic [TIME_W-1:0]   now_ms;

	modport source (output valid, func, msg_id, peer_call, now_ms, input ready);
	modport sink (input valid, func, msg_id, peer_call, now_ms, output ready);
endinterface

interface art_rsp_if import art_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [EVENT_W-1:0]  event_res;
	logic [SLOT_W-1:0]   slot;
	logic [MSG_ID_W-1:0] msg_id_out;
	logic [PEER_W-1:0]   peer_out;
	logic [RETRY_W-1:0]  retry_count;
	logic                last;

	modport source (output valid, event_res, slot, msg_id_out, peer_out, retry_count, last,
		input ready);
	modport sink (input valid, event_res, slot, msg_id_out, peer_out, retry_count, last,
		output ready);
endinterface

interface art_cfg_if import art_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ===== hw/rtl/art_ctrl.sv =====
// ----------------------------------------------------------------------------
// art_ctrl
// Sequencer of the tracker: accepts one item, walks the slot table for
// ack and scan, and issues store and emit commands to the datapath.
// ----------------------------------------------------------------------------
module art_ctrl import art_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	input  logic [FUNC_W-1:0] req_func,
	output logic              req_ready,
	input  art_sts_t          sts,
	output art_cmd_t          cmd
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ADD,
		ST_ACK,
		ST_SCAN,
		ST_DONE
	} state_t;

	state_t state_q;
	state_t state_d;

	assign req_ready = (state_q == ST_IDLE);

	// Decode commands and next state
	always_comb begin
		cmd     = '0;
		cmd.ev  = EV_DONE;
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				cmd.idx_clr = 1'b1;
				if (req_valid) begin
					cmd.req_ld = 1'b1;
					case (req_func)
						FN_ADD:  state_d = ST_ADD;
						FN_ACK:  state_d = ST_ACK;
						FN_SCAN: state_d = ST_SCAN;
						default: state_d = ST_IDLE;
					endcase
				end
			end
			ST_ADD: begin
				if (sts.out_free) begin
					cmd.emit   = 1'b1;
					cmd.last   = 1'b1;
					cmd.ev     = sts.any_free ? EV_ADDED : EV_FULL;
					cmd.add_wr = sts.any_free;
					state_d    = ST_IDLE;
				end
			end
			ST_ACK: begin
				if (sts.hit) begin
					if (sts.out_free) begin
						cmd.emit      = 1'b1;
						cmd.last      = 1'b1;
						cmd.ev        = EV_ACK_OK;
						cmd.slot_free = 1'b1;
						state_d       = ST_IDLE;
					end
				end else if (sts.idx_last) begin
					if (sts.out_free) begin
						cmd.emit = 1'b1;
						cmd.last = 1'b1;
						cmd.ev   = EV_ACK_NONE;
						state_d  = ST_IDLE;
					end
				end else begin
					cmd.idx_inc = 1'b1;
				end
			end
			ST_SCAN: begin
				if (sts.expired) begin
					if (sts.out_free) begin
						cmd.emit       = 1'b1;
						cmd.ev         = sts.at_limit ? EV_FAIL : EV_RETRY;
						cmd.slot_free  = sts.at_limit;
						cmd.slot_retry = !sts.at_limit;
						cmd.idx_inc    = !sts.idx_last;
						if (sts.idx_last) begin
							state_d = ST_DONE;
						end
					end
				end else begin
					cmd.idx_inc = !sts.idx_last;
					if (sts.idx_last) begin
						state_d = ST_DONE;
					end
				end
			end
			ST_DONE: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					cmd.last = 1'b1;
					cmd.ev   = EV_DONE;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Hold state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// A final result always returns the sequencer to idle
	a_last_to_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit && cmd.last) |=> (state_q == ST_IDLE))
		else $error("final result did not end the item");

endmodule

// ===== hw/rtl/art_dp.sv =====
// ----------------------------------------------------------------------------
// art_dp
// Datapath of the tracker: request latch, configuration registers, slot
// table with its walk index, expiry and match logic, result register.
// ----------------------------------------------------------------------------
module art_dp import art_pkg::*; #(
	parameter int SLOTS = 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// request payload
	input  logic [MSG_ID_W-1:0]   req_msg_id,
	input  logic [PEER_W-1:0]     req_peer_call,
	input  logic [TIME_W-1:0]     req_now_ms,
	// configuration write
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	// result channel
	output logic                  rsp_valid,
	input  logic                  rsp_ready,
	output logic [EVENT_W-1:0]    rsp_event_res,
	output logic [SLOT_W-1:0]     rsp_slot,
	output logic [MSG_ID_W-1:0]   rsp_msg_id_out,
	output logic [PEER_W-1:0]     rsp_peer_out,
	output logic [RETRY_W-1:0]    rsp_retry_count,
	output logic                  rsp_last,
	// control
	input  art_cmd_t              cmd,
	output art_sts_t              sts
);

	localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam logic [IW-1:0] IDX_LAST = IW'(SLOTS - 1);

	// configuration
	logic [TIMEOUT_W-1:0] ack_timeout_q;
	logic [RETRY_W-1:0]   retry_limit_q;

	// request latch
	logic [MSG_ID_W-1:0] id_q;
	logic [PEER_W-1:0]   peer_q;
	logic [TIME_W-1:0]   now_q;

	// slot table
	logic [SLOTS-1:0]    valid_q;
	logic [MSG_ID_W-1:0] tab_id_q    [SLOTS];
	logic [PEER_W-1:0]   tab_peer_q  [SLOTS];
	logic [TIME_W-1:0]   tab_stamp_q [SLOTS];
	logic [RETRY_W-1:0]  tab_retry_q [SLOTS];

	logic [IW-1:0] idx_q;

	// result register
	logic                out_valid_q;
	event_t              out_ev_q;
	logic [SLOT_W-1:0]   out_slot_q;
	logic [MSG_ID_W-1:0] out_id_q;
	logic [PEER_W-1:0]   out_peer_q;
	logic [RETRY_W-1:0]  out_retry_q;
	logic                out_last_q;

	// walked slot view
	logic [MSG_ID_W-1:0] cur_id;
	logic [PEER_W-1:0]   cur_peer;
	logic [TIME_W-1:0]   cur_age;
	logic [RETRY_W-1:0]  cur_retry;
	logic [RETRY_W-1:0]  cur_retry_inc;
	logic [IW-1:0]       free_idx;
	logic [IW+2:0]       idx_ext;
	logic [IW+2:0]       free_ext;
	logic [SLOT_W-1:0]   nxt_slot;
	logic [MSG_ID_W-1:0] nxt_id;
	logic [PEER_W-1:0]   nxt_peer;
	logic [RETRY_W-1:0]  nxt_retry;

	assign cfg_ready = 1'b1;

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ack_timeout_q <= ACK_TIMEOUT_RST;
			retry_limit_q <= RETRY_LIMIT_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_ACK_TIMEOUT: ack_timeout_q <= cfg_data;
				CFG_RETRY_LIMIT: retry_limit_q <= cfg_data[RETRY_W-1:0];
				default: ;
			endcase
		end
	end

	// Latch the accepted request
	always_ff @(posedge clk) begin
		if (cmd.req_ld) begin
			id_q   <= req_msg_id;
			peer_q <= req_peer_call;
			now_q  <= req_now_ms;
		end
	end

	// Read the walked slot
	assign cur_id        = tab_id_q[idx_q];
	assign cur_peer      = tab_peer_q[idx_q];
	assign cur_age       = now_q - tab_stamp_q[idx_q];
	assign cur_retry     = tab_retry_q[idx_q];
	assign cur_retry_inc = cur_retry + 1'b1;

	// Find the lowest free slot
	always_comb begin
		free_idx = '0;
		for (int i = SLOTS - 1; i >= 0; i--) begin
			if (!valid_q[i]) begin
				free_idx = IW'(i);
			end
		end
	end

	assign sts.any_free = ~&valid_q;
	assign sts.hit      = valid_q[idx_q] && (cur_id == id_q) && (cur_peer == peer_q);
	assign sts.expired  = valid_q[idx_q] && (cur_age >= TIME_W'(ack_timeout_q));
	assign sts.at_limit = (cur_retry >= retry_limit_q);
	assign sts.idx_last = (idx_q == IDX_LAST);
	assign sts.out_free = !out_valid_q || rsp_ready;

	// Advance the slot walk
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
		end else if (cmd.idx_clr) begin
			idx_q <= '0;
		end else if (cmd.idx_inc) begin
			idx_q <= idx_q + 1'b1;
		end
	end

	// Set and drop slot valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (cmd.add_wr) begin
			valid_q[free_idx] <= 1'b1;
		end else if (cmd.slot_free) begin
			valid_q[idx_q] <= 1'b0;
		end
	end

	// Store slot contents
	always_ff @(posedge clk) begin
		if (cmd.add_wr) begin
			tab_id_q[free_idx]    <= id_q;
			tab_peer_q[free_idx]  <= peer_q;
			tab_stamp_q[free_idx] <= now_q;
			tab_retry_q[free_idx] <= '0;
		end else if (cmd.slot_retry) begin
			tab_stamp_q[idx_q] <= now_q;
			tab_retry_q[idx_q] <= cur_retry_inc;
		end
	end

	// Select the result payload
	assign idx_ext  = (IW + 3)'(idx_q);
	assign free_ext = (IW + 3)'(free_idx);

	always_comb begin
		nxt_slot  = '0;
		nxt_id    = id_q;
		nxt_peer  = peer_q;
		nxt_retry = '0;
		case (cmd.ev)
			EV_ADDED: nxt_slot = free_ext[SLOT_W-1:0];
			EV_ACK_OK: begin
				nxt_slot  = idx_ext[SLOT_W-1:0];
				nxt_retry = cur_retry;
			end
			EV_RETRY: begin
				nxt_slot  = idx_ext[SLOT_W-1:0];
				nxt_id    = cur_id;
				nxt_peer  = cur_peer;
				nxt_retry = cur_retry_inc;
			end
			EV_FAIL: begin
				nxt_slot  = idx_ext[SLOT_W-1:0];
				nxt_id    = cur_id;
				nxt_peer  = cur_peer;
				nxt_retry = cur_retry;
			end
			EV_DONE: begin
				nxt_id   = '0;
				nxt_peer = '0;
			end
			default: ;
		endcase
	end

	// Hold the result until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_ev_q    <= cmd.ev;
			out_slot_q  <= nxt_slot;
			out_id_q    <= nxt_id;
			out_peer_q  <= nxt_peer;
			out_retry_q <= nxt_retry;
			out_last_q  <= cmd.last;
		end
	end

	assign rsp_valid       = out_valid_q;
	assign rsp_event_res   = out_ev_q;
	assign rsp_slot        = out_slot_q;
	assign rsp_msg_id_out  = out_id_q;
	assign rsp_peer_out    = out_peer_q;
	assign rsp_retry_count = out_retry_q;
	assign rsp_last        = out_last_q;

	// A new result never overwrites one still waiting
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> (!out_valid_q || rsp_ready))
		else $error("result register overwritten");

	// An add occupies exactly one more slot
	a_add_fills: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.add_wr |=> ($countones(valid_q) == $past($countones(valid_q)) + 1))
		else $error("add did not occupy one slot");

	// A freed slot is no longer valid
	a_free_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.slot_free && !cmd.add_wr) |=> !valid_q[$past(idx_q)])
		else $error("freed slot still valid");

endmodule

// ===== hw/rtl/ack_retry_tracker.sv =====
// ----------------------------------------------------------------------------
// ack_retry_tracker
// Table of pending acknowledgements with retry timing.
// ----------------------------------------------------------------------------
// Usage:
//   req  : one item per operation: func (add, ack, scan), msg_id, peer_call,
//          now_ms. Taken when req.valid and req.ready are high.
//   rsp  : result items (event_res, slot, msg_id_out, peer_out, retry_count,
//          last). An add or ack gives one result, a scan gives one result
//          per expired slot plus a closing scan-done result; last marks the
//          final result of the item. An unused func code gives no result.
//   cfg  : register writes (0 ack_timeout, 1 retry_limit), always ready;
//          write only while no item is in progress.
// Timing: an add gives its result from its own state, an ack walks the slot table up
//   to a hit or the final slot, a scan walks every slot and then closes; the next item is
//   taken the cycle after the final result is loaded. The walk moves over the slot
//   table one slot per cycle through its single read port, unless a result is not taken.
// Reset: all slots free, ack_timeout 1200 ms, retry_limit 3; no clearing pass.
// Stall: a result waits in the output register; while it is not taken the
//   walk holds at the slot that produced the next result.
// ----------------------------------------------------------------------------
module ack_retry_tracker import art_pkg::*; #(
	parameter int SLOTS = 8
) (
	input  logic       clk,
	input  logic       arst_n,
	art_req_if.sink    req,
	art_rsp_if.source  rsp,
	art_cfg_if.sink    cfg
);

	art_cmd_t cmd;
	art_sts_t sts;

	// Sequencer
	art_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_func  (req.func),
		.req_ready (req.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// Slot table and result register
	art_dp #(
		.SLOTS (SLOTS)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.req_msg_id      (req.msg_id),
		.req_peer_call   (req.peer_call),
		.req_now_ms      (req.now_ms),
		.cfg_valid       (cfg.valid),
		.cfg_ready       (cfg.ready),
		.cfg_index       (cfg.index),
		.cfg_data        (cfg.data),
		.rsp_valid       (rsp.valid),
		.rsp_ready       (rsp.ready),
		.rsp_event_res   (rsp.event_res),
		.rsp_slot        (rsp.slot),
		.rsp_msg_id_out  (rsp.msg_id_out),
		.rsp_peer_out    (rsp.peer_out),
		.rsp_retry_count (rsp.retry_count),
		.rsp_last        (rsp.last),
		.cmd             (cmd),
		.sts             (sts)
	);

endmodule

// ===== sim/tb_ack_retry_tracker.sv =====
// ----------------------------------------------------------------------------
// tb_ack_retry_tracker
// Self-checking bench for the pending-acknowledgement tracker. A queue of
// request items feeds a clocked driver; a clocked monitor takes results
// under random backpressure and checks them field by field against a
// slot-table predictor updated at each accepted request. The run starts
// with a directed sequence (wraparound ages, full table, duplicate adds, a
// nine-result scan, retry exhaustion), then goes through several register
// settings and idle patterns with random add/ack/scan traffic.
// ----------------------------------------------------------------------------
module tb_ack_retry_tracker import art_pkg::*; ();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int SLOTS         = 8;
	localparam int SETTLE_CYCLES = 16;
	localparam int CYCLE_LIMIT   = 600000;
	localparam int PHASES        = 8;
	localparam int PHASE_ITEMS   = 60;
	localparam int MAX_REPORTS   = 10;
	localparam int MAX_TRACKED   = 16;

	// func code that the block ignores
	localparam logic [FUNC_W-1:0] FN_UNUSED = 2'd3;

	typedef struct packed {
		logic [FUNC_W-1:0]   func;
		logic [MSG_ID_W-1:0] msg_id;
		logic [PEER_W-1:0]   peer;
		logic [TIME_W-1:0]   now;
	} req_item_t;

	typedef struct {
		event_t              ev;
		logic [SLOT_W-1:0]   slot;
		logic [MSG_ID_W-1:0] msg_id;
		logic [PEER_W-1:0]   peer;
		logic [RETRY_W-1:0]  retries;
		logic                last;
	} tracker_event_t;

	typedef struct {
		logic [MSG_ID_W-1:0] id;
		logic [PEER_W-1:0]   peer;
	} pend_pair_t;

	logic clk;
	logic arst_n;

	art_req_if req_ch();
	art_rsp_if rsp_ch();
	art_cfg_if cfg_ch();

	ack_retry_tracker #(.SLOTS(SLOTS)) uut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch),
		.cfg    (cfg_ch)
	);

	// Predicted slot table and register copies
	logic                tbl_valid   [SLOTS];
	logic [MSG_ID_W-1:0] tbl_id      [SLOTS];
	logic [PEER_W-1:0]   tbl_peer    [SLOTS];
	logic [TIME_W-1:0]   tbl_stamp   [SLOTS];
	logic [RETRY_W-1:0]  tbl_retries [SLOTS];
	logic [TIMEOUT_W-1:0] timeout_ms;
	logic [RETRY_W-1:0]   retry_max;

	req_item_t      req_queue[$];
	tracker_event_t expected_events[$];
	pend_pair_t     outstanding_pairs[$];
	req_item_t      cur_req;

	int send_idle_pct;
	int recv_stall_pct;
	int fault_count;
	int settings_run;
	int items_by_func [4];
	int ev_seen [7];
	logic [TIME_W-1:0] clock_ms;

	// Clock
	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Watchdog
	initial begin : watchdog
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("timeout: %0d cycles without finishing", CYCLE_LIMIT);
		$display("FAILED: results differ");
		$finish;
	end

	function automatic void push_event(event_t ev, int idx, logic [MSG_ID_W-1:0] id,
		logic [PEER_W-1:0] peer, logic [RETRY_W-1:0] rc, logic fin);
		tracker_event_t e;
		e.ev      = ev;
		e.slot    = SLOT_W'(idx);
		e.msg_id  = id;
		e.peer    = peer;
		e.retries = rc;
		e.last    = fin;
		expected_events.push_back(e);
	endfunction

	// Update the table for one accepted request and queue its results
	function automatic void predict_events(req_item_t it);
		logic [TIME_W-1:0] age;
		bit found;
		found = 1'b0;
		case (it.func)
			FN_ADD: begin
				for (int i = 0; i < SLOTS; i++) begin
					if (!found && !tbl_valid[i]) begin
						found          = 1'b1;
						tbl_valid[i]   = 1'b1;
						tbl_id[i]      = it.msg_id;
						tbl_peer[i]    = it.peer;
						tbl_stamp[i]   = it.now;
						tbl_retries[i] = '0;
						push_event(EV_ADDED, i, it.msg_id, it.peer, '0, 1'b1);
					end
				end
				if (!found)
					push_event(EV_FULL, 0, it.msg_id, it.peer, '0, 1'b1);
			end
			FN_ACK: begin
				for (int i = 0; i < SLOTS; i++) begin
					if (!found && tbl_valid[i] && tbl_id[i] == it.msg_id &&
						tbl_peer[i] == it.peer) begin
						found        = 1'b1;
						tbl_valid[i] = 1'b0;
						push_event(EV_ACK_OK, i, it.msg_id, it.peer, tbl_retries[i], 1'b1);
					end
				end
				if (!found)
					push_event(EV_ACK_NONE, 0, it.msg_id, it.peer, '0, 1'b1);
			end
			FN_SCAN: begin
				for (int i = 0; i < SLOTS; i++) begin
					age = it.now - tbl_stamp[i];
					if (tbl_valid[i] && age >= TIME_W'(timeout_ms)) begin
						if (tbl_retries[i] >= retry_max) begin
							tbl_valid[i] = 1'b0;
							push_event(EV_FAIL, i, tbl_id[i], tbl_peer[i], tbl_retries[i], 1'b0);
						end else begin
							tbl_retries[i] = tbl_retries[i] + 1'b1;
							tbl_stamp[i]   = it.now;
							push_event(EV_RETRY, i, tbl_id[i], tbl_peer[i], tbl_retries[i], 1'b0);
						end
					end
				end
				push_event(EV_DONE, 0, '0, '0, '0, 1'b1);
			end
			default: ;
		endcase
	endfunction

	function automatic void report_fault(string msg);
		if (fault_count < MAX_REPORTS)
			$display("%s", msg);
		fault_count++;
	endfunction

	// Random peer: raw 56 bits or a space-padded callsign
	function automatic logic [PEER_W-1:0] make_peer();
		logic [PEER_W-1:0] p;
		int len;
		logic [7:0] c;
		if ($urandom_range(0, 1) == 0) begin
			p[31:0]  = $urandom();
			p[55:32] = 24'($urandom());
		end else begin
			len = $urandom_range(3, 7);
			for (int b = 0; b < 7; b++) begin
				if (b >= len)
					c = " ";
				else if ($urandom_range(0, 3) == 0)
					c = 8'("0" + $urandom_range(0, 9));
				else
					c = 8'("A" + $urandom_range(0, 25));
				p[55 - 8*b -: 8] = c;
			end
		end
		return p;
	endfunction

	function automatic void queue_req(logic [FUNC_W-1:0] f, logic [MSG_ID_W-1:0] id,
		logic [PEER_W-1:0] peer, logic [TIME_W-1:0] now);
		req_item_t it;
		it.func   = f;
		it.msg_id = id;
		it.peer   = peer;
		it.now    = now;
		req_queue.push_back(it);
	endfunction

	// Driver: present queued requests, predict on acceptance
	always @(posedge clk) begin : req_driver
		if (arst_n) begin
			if (req_ch.valid && req_ch.ready) begin
				predict_events(cur_req);
				items_by_func[cur_req.func]++;
			end
			if (!req_ch.valid || req_ch.ready) begin
				if (req_queue.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
					cur_req          = req_queue.pop_front();
					req_ch.valid     <= 1'b1;
					req_ch.func      <= cur_req.func;
					req_ch.msg_id    <= cur_req.msg_id;
					req_ch.peer_call <= cur_req.peer;
					req_ch.now_ms    <= cur_req.now;
				end else begin
					req_ch.valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: check each taken result against the oldest prediction
	always @(posedge clk) begin : rsp_monitor
		tracker_event_t e;
		if (arst_n) begin
			if (rsp_ch.valid && rsp_ch.ready) begin
				if (rsp_ch.event_res <= EV_DONE)
					ev_seen[rsp_ch.event_res]++;
				if (expected_events.size() == 0) begin
					report_fault($sformatf("unexpected result ev=%0d slot=%0d id=%h",
						rsp_ch.event_res, rsp_ch.slot, rsp_ch.msg_id_out));
				end else begin
					e = expected_events.pop_front();
					if (rsp_ch.event_res !== e.ev || rsp_ch.slot !== e.slot ||
						rsp_ch.msg_id_out !== e.msg_id || rsp_ch.peer_out !== e.peer ||
						rsp_ch.retry_count !== e.retries || rsp_ch.last !== e.last)
						report_fault($sformatf({"mismatch: exp ev=%0d slot=%0d id=%h peer=%h ",
							"rc=%0d last=%0b / got ev=%0d slot=%0d id=%h peer=%h rc=%0d last=%0b"},
							e.ev, e.slot, e.msg_id, e.peer, e.retries, e.last,
							rsp_ch.event_res, rsp_ch.slot, rsp_ch.msg_id_out, rsp_ch.peer_out,
							rsp_ch.retry_count, rsp_ch.last));
				end
			end
			rsp_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
		end
	end

	// Hold until nothing is queued, presented or expected, then settle
	task automatic wait_idle();
		do @(negedge clk);
		while (req_queue.size() != 0 || req_ch.valid || expected_events.size() != 0);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		@(posedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= val;
		do @(posedge clk);
		while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
		if (idx == CFG_ACK_TIMEOUT)
			timeout_ms = TIMEOUT_W'(val);
		else if (idx == CFG_RETRY_LIMIT)
			retry_max = RETRY_W'(val);
		@(negedge clk);
	endtask

	// Directed: wrapped ages, full table, duplicates, 9-result scan, exhaustion
	task automatic run_directed();
		logic [TIME_W-1:0] t0;
		t0 = 32'hFFFF_FF00;
		queue_req(FN_ACK, 16'hFFFF, {PEER_W{1'b1}}, t0);
		queue_req(FN_ADD, 16'h0000, '0, t0);
		queue_req(FN_ADD, 16'h0000, '0, t0);
		queue_req(FN_ADD, 16'hFFFF, {PEER_W{1'b1}}, t0);
		queue_req(FN_ADD, 16'h1234, "AB1CD  ", t0);
		queue_req(FN_ADD, 16'h8001, "ZZ9ZZZ ", t0);
		queue_req(FN_ADD, 16'h5A5A, 56'h55AA55AA55AA55, t0);
		queue_req(FN_ADD, 16'hA5A5, 56'hAA55AA55AA55AA, t0);
		queue_req(FN_ADD, 16'h7FFF, "K1X    ", t0);
		queue_req(FN_ADD, 16'hABCD, "Q0Q    ", t0);
		queue_req(FN_SCAN, 16'hFFFF, {PEER_W{1'b1}}, t0 + 32'd1199);
		queue_req(FN_SCAN, '0, '0, t0 + 32'd1200);
		queue_req(FN_ACK, 16'h0000, '0, t0 + 32'd1300);
		queue_req(FN_ACK, 16'hFFFF, '0, t0 + 32'd1300);
		queue_req(FN_UNUSED, 16'hFFFF, {PEER_W{1'b1}}, 32'hFFFF_FFFF);
		queue_req(FN_SCAN, '0, '0, t0 + 32'd2400);
		queue_req(FN_SCAN, '0, '0, t0 + 32'd3600);
		queue_req(FN_SCAN, '0, '0, t0 + 32'd4800);
		clock_ms = t0 + 32'd4800;
	endtask

	// Random traffic: mostly add/ack/scan on tracked IDs, some noise
	task automatic gen_phase(int n_items);
		req_item_t it;
		int made;
		int r;
		int k;
		int step_max;
		pend_pair_t pr;
		made     = 0;
		step_max = (timeout_ms == 0) ? 64 : int'(timeout_ms) / 3 + 1;
		while (made < n_items) begin
			r         = $urandom_range(0, 99);
			clock_ms  = clock_ms + TIME_W'($urandom_range(0, step_max));
			it.now    = clock_ms;
			it.msg_id = MSG_ID_W'($urandom());
			it.peer   = make_peer();
			if (r < 35) begin
				it.func = FN_ADD;
				if (outstanding_pairs.size() > 0 && $urandom_range(0, 4) == 0) begin
					pr        = outstanding_pairs[$urandom_range(0, outstanding_pairs.size() - 1)];
					it.msg_id = pr.id;
					it.peer   = pr.peer;
				end
				if (outstanding_pairs.size() < MAX_TRACKED)
					outstanding_pairs.push_back('{it.msg_id, it.peer});
			end else if (r < 60) begin
				it.func = FN_ACK;
				if (outstanding_pairs.size() > 0 && $urandom_range(0, 9) != 0) begin
					k         = $urandom_range(0, outstanding_pairs.size() - 1);
					it.msg_id = outstanding_pairs[k].id;
					it.peer   = outstanding_pairs[k].peer;
					// right ID, wrong peer
					if ($urandom_range(0, 7) == 0)
						it.peer[$urandom_range(0, PEER_W - 1)] ^= 1'b1;
					outstanding_pairs.delete(k);
				end
			end else if (r < 85) begin
				it.func = FN_SCAN;
			end else begin
				case ($urandom_range(0, 2))
					0: it.func = FN_UNUSED;
					1: begin
						clock_ms = $urandom();
						it.now   = clock_ms;
						it.func  = FN_SCAN;
					end
					default: it.func = FN_ACK;
				endcase
			end
			req_queue.push_back(it);
			if (it.func != FN_UNUSED)
				made++;
		end
	endtask

	// Main sequence
	initial begin : main_seq
		logic [CFG_DATA_W-1:0] tmo;
		logic [CFG_DATA_W-1:0] lim;
		arst_n           = 1'b0;
		req_ch.valid     = 1'b0;
		req_ch.func      = '0;
		req_ch.msg_id    = '0;
		req_ch.peer_call = '0;
		req_ch.now_ms    = '0;
		rsp_ch.ready     = 1'b0;
		cfg_ch.valid     = 1'b0;
		cfg_ch.index     = '0;
		cfg_ch.data      = '0;
		timeout_ms       = ACK_TIMEOUT_RST;
		retry_max        = RETRY_LIMIT_RST;
		send_idle_pct    = 0;
		recv_stall_pct   = 0;
		fault_count      = 0;
		settings_run     = 1;
		clock_ms         = '0;
		for (int i = 0; i < SLOTS; i++)
			tbl_valid[i] = 1'b0;
		foreach (items_by_func[i])
			items_by_func[i] = 0;
		foreach (ev_seen[i])
			ev_seen[i] = 0;

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		run_directed();
		wait_idle();

		// Register settings and idle pattern per phase
		for (int p = 0; p < PHASES; p++) begin
			case (p)
				0: begin tmo = 20'd1200;    lim = 20'd3;  end
				1: begin tmo = 20'd0;       lim = 20'd0;  end
				2: begin tmo = 20'd1;       lim = 20'd15; end
				3: begin tmo = 20'd1000000; lim = 20'd2;  end
				4: begin
					tmo = CFG_DATA_W'($urandom_range(2, 3000));
					lim = CFG_DATA_W'($urandom_range(0, 15));
				end
				5: begin tmo = 20'd250;     lim = 20'd1;  end
				6: begin
					tmo = CFG_DATA_W'($urandom_range(1, 1000000));
					lim = CFG_DATA_W'($urandom_range(0, 15));
				end
				default: begin tmo = 20'd300; lim = 20'd15; end
			endcase
			write_reg(CFG_ACK_TIMEOUT, tmo);
			write_reg(CFG_RETRY_LIMIT, lim);
			settings_run++;
			case (p % 4)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 56; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 56; end
				default: begin send_idle_pct = 29; recv_stall_pct = 29; end
			endcase
			gen_phase(PHASE_ITEMS);
			wait_idle();
		end

		fault_count += expected_events.size();
		$display("Run covered %0d adds, %0d acks, %0d scans, %0d unused codes over %0d settings",
			items_by_func[FN_ADD], items_by_func[FN_ACK], items_by_func[FN_SCAN],
			items_by_func[FN_UNUSED], settings_run);
		$display({"Results: added %0d, full %0d, ack hit %0d, ack miss %0d, retry %0d, ",
			"failed %0d, scan done %0d; faults %0d"},
			ev_seen[EV_ADDED], ev_seen[EV_FULL], ev_seen[EV_ACK_OK], ev_seen[EV_ACK_NONE],
			ev_seen[EV_RETRY], ev_seen[EV_FAIL], ev_seen[EV_DONE], fault_count);
		if (fault_count == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule

// ===== sim.f =====
hw/rtl/art_pkg.sv
hw/rtl/art_if.sv
hw/rtl/art_ctrl.sv
hw/rtl/art_dp.sv
hw/rtl/ack_retry_tracker.sv
sim/tb_ack_retry_tracker.sv
